// ===== design/cpmi_pkg.sv =====
// Shared types, constants and tables of the cubic polynomial map iterator.
// Used by every module of the design; depends on nothing.
`default_nettype none

package cpmi_pkg;

  localparam int FRAC        = 24;
  localparam int NDIM        = 3;
  localparam int NUM_TERMS   = 20;
  localparam int STORE_DEPTH = 60;
  localparam int WORD_W      = 32;
  localparam int ACC_W       = 48;
  localparam int RND_W       = 2 * WORD_W - FRAC;
  localparam int SQ_W        = 2 * WORD_W - FRAC;
  localparam int DIST_W      = SQ_W + 2;
  localparam int RAD_W       = 40;
  localparam int ADDR_W      = 6;
  localparam int TERM_W      = 5;
  localparam int CNT_W       = 7;
  localparam int RUN_OPS     = 4 * NUM_TERMS;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 40'd1677721600;
  localparam logic signed [WORD_W-1:0] ONE = 32'sd16777216;
  localparam logic [4:0] CODE_MOD = 5'd25;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_STEP  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_FACTOR = 2'd1,
    OP_COEF   = 2'd2,
    OP_SQUARE = 2'd3
  } op_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINAL,
    ST_SQUARE,
    ST_SQDRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [TERM_W-1:0] term;
    logic [1:0]        dim;
  } op_t;

  typedef struct packed {
    op_t  op;
    logic finalize;
    logic res_load;
  } ctl_t;

  function automatic logic [TERM_W-1:0] parent_of(input logic [TERM_W-1:0] t);
    logic [TERM_W-1:0] p;
    unique case (t)
      5'd2, 5'd6, 5'd9:         p = 5'd1;
      5'd3, 5'd4, 5'd5:         p = 5'd2;
      5'd7, 5'd8:               p = 5'd6;
      5'd10:                    p = 5'd9;
      5'd12, 5'd15:             p = 5'd11;
      5'd13, 5'd14:             p = 5'd12;
      5'd16:                    p = 5'd15;
      5'd18:                    p = 5'd17;
      5'd19:                    p = 5'd18;
      default:                  p = 5'd0;
    endcase
    return p;
  endfunction

  function automatic logic [1:0] dim_of(input logic [TERM_W-1:0] t);
    logic [1:0] d;
    unique case (t)
      5'd1, 5'd2, 5'd3:                             d = 2'd0;
      5'd4, 5'd6, 5'd7, 5'd11, 5'd12, 5'd13:        d = 2'd1;
      default:                                      d = 2'd2;
    endcase
    return d;
  endfunction

  function automatic logic signed [WORD_W-1:0] coef_value(input logic [4:0] code);
    logic [4:0]               mag;
    logic signed [WORD_W-1:0] v;
    mag = (code >= 5'd12) ? code - 5'd12 : 5'd12 - code;
    unique case (mag)
      5'd0:    v = 32'sd0;
      5'd1:    v = 32'sd1677722;
      5'd2:    v = 32'sd3355443;
      5'd3:    v = 32'sd5033165;
      5'd4:    v = 32'sd6710886;
      5'd5:    v = 32'sd8388608;
      5'd6:    v = 32'sd10066330;
      5'd7:    v = 32'sd11744051;
      5'd8:    v = 32'sd13421773;
      5'd9:    v = 32'sd15099494;
      5'd10:   v = 32'sd16777216;
      5'd11:   v = 32'sd18454938;
      5'd12:   v = 32'sd20132659;
      default: v = 32'sd0;
    endcase
    return (code < 5'd12) ? -v : v;
  endfunction

endpackage

`default_nettype wire

// ===== design/cubic_poly_map_iterator.sv =====
// Top level of the cubic polynomial map iterator: handshake, APB register, result register.
// Depends on cpmi_pkg, cpmi_seq and cpmi_dpath.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   request  | in_valid/in_ready  | func, coeff_index, coeff_code
//   result   | out_valid/out_ready| pos_x, pos_y, pos_z, escaped, overflowed
//   config   | APB psel/penable   | paddr (1 bit), pwdata/prdata (64 bits)
//
// Load and clear requests take effect at the edge that accepts them. A step request
// runs RUN (the single 32x32 multiplier: 19 factors, 60 coefficient products, one idle
// slot), DRAIN, FINAL (saturate), SQUARE (3 squares), SQDRAIN and DONE (result load).
// Reset clears the position and the sticky flag and sets the radius register to
// 100.0; the coefficient store holds nothing until loaded. A result waiting on
// out_ready does not stop new requests; only a second finished step waits for it.
`default_nettype none

module cubic_poly_map_iterator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [5:0]  coeff_index,
  input  wire logic [4:0]  coeff_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic             escaped,
  output logic             overflowed,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  cpmi_pkg::ctl_t                         ctl;
  logic                                   busy, accept, step_start, pos_clear, load_we;
  logic                                   out_free;
  logic [4:0]                             code_wrap;
  logic [cpmi_pkg::RAD_W-1:0]             radius;
  logic signed [cpmi_pkg::WORD_W-1:0]     pos [cpmi_pkg::NDIM];
  logic [cpmi_pkg::DIST_W-1:0]            dist_sq;
  logic                                   sat_seen;

  assign pready     = 1'b1;
  assign prdata     = (paddr == 1'b0) ? 64'(radius) : '0;
  assign in_ready   = !busy;
  assign accept     = in_valid && in_ready;
  assign step_start = accept && (func == cpmi_pkg::FUNC_STEP);
  assign pos_clear  = accept && (func == cpmi_pkg::FUNC_CLEAR);
  assign load_we    = accept && (func == cpmi_pkg::FUNC_LOAD)
                    && (coeff_index < cpmi_pkg::ADDR_W'(cpmi_pkg::STORE_DEPTH));
  assign code_wrap  = (coeff_code >= cpmi_pkg::CODE_MOD) ? coeff_code - cpmi_pkg::CODE_MOD
                                                         : coeff_code;
  assign out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= cpmi_pkg::RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == 1'b0) begin
      radius <= pwdata[cpmi_pkg::RAD_W-1:0];
    end
  end

  cpmi_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (step_start),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl)
  );

  cpmi_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .step_start (step_start),
    .pos_clear  (pos_clear),
    .load_we    (load_we),
    .load_addr  (coeff_index),
    .load_data  (cpmi_pkg::coef_value(code_wrap)),
    .pos        (pos),
    .dist_sq    (dist_sq),
    .sat_seen   (sat_seen)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      pos_x      <= pos[0];
      pos_y      <= pos[1];
      pos_z      <= pos[2];
      escaped    <= (dist_sq > cpmi_pkg::DIST_W'(radius));
      overflowed <= sat_seen;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.res_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    step_start |=> !in_ready)
    else $error("request taken while a step is running");

  a_clear_flag: assert property (@(posedge clk) disable iff (rst)
    pos_clear |=> !sat_seen)
    else $error("saturation flag survived a clear");

endmodule

`default_nettype wire

// ===== design/cpmi_coef_mem.sv =====
// Coefficient store: 60 words, one write port, one read port, registered read.
// Depends on cpmi_pkg.
`default_nettype none

module cpmi_coef_mem (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [cpmi_pkg::ADDR_W-1:0]         waddr,
  input  wire logic signed [cpmi_pkg::WORD_W-1:0]  wdata,
  input  wire logic [cpmi_pkg::ADDR_W-1:0]         raddr,
  output logic signed [cpmi_pkg::WORD_W-1:0]       rdata
);

  logic signed [cpmi_pkg::WORD_W-1:0] mem [cpmi_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/cpmi_seq.sv =====
// Step sequencer: walks factor, coefficient and square operations.
// Depends on cpmi_pkg.
`default_nettype none

module cpmi_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic           out_free,
  output logic                busy,
  output cpmi_pkg::ctl_t      ctl
);

  cpmi_pkg::state_t                 state, state_next;
  logic [cpmi_pkg::CNT_W-1:0]       count, count_next;
  logic [cpmi_pkg::TERM_W-1:0]      slot;
  logic [1:0]                       sub;

  assign slot = count[cpmi_pkg::CNT_W-1:2];
  assign sub  = count[1:0];

  always_comb begin
    state_next = state;
    count_next = count + 1'b1;
    unique case (state)
      cpmi_pkg::ST_IDLE: begin
        count_next = '0;
        if (start) state_next = cpmi_pkg::ST_RUN;
      end
      cpmi_pkg::ST_RUN: begin
        if (count == cpmi_pkg::CNT_W'(cpmi_pkg::RUN_OPS - 1)) begin
          state_next = cpmi_pkg::ST_DRAIN;
          count_next = '0;
        end
      end
      cpmi_pkg::ST_DRAIN: begin
        if (count == cpmi_pkg::CNT_W'(1)) state_next = cpmi_pkg::ST_FINAL;
      end
      cpmi_pkg::ST_FINAL: begin
        state_next = cpmi_pkg::ST_SQUARE;
        count_next = '0;
      end
      cpmi_pkg::ST_SQUARE: begin
        if (count == cpmi_pkg::CNT_W'(cpmi_pkg::NDIM - 1)) begin
          state_next = cpmi_pkg::ST_SQDRAIN;
          count_next = '0;
        end
      end
      cpmi_pkg::ST_SQDRAIN: begin
        if (count == cpmi_pkg::CNT_W'(1)) state_next = cpmi_pkg::ST_DONE;
      end
      cpmi_pkg::ST_DONE: begin
        if (out_free) state_next = cpmi_pkg::ST_IDLE;
      end
      default: state_next = cpmi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.op.kind  = cpmi_pkg::OP_NONE;
    busy         = (state != cpmi_pkg::ST_IDLE);
    unique case (state)
      cpmi_pkg::ST_RUN: begin
        if (sub == 2'd0) begin
          if (slot < cpmi_pkg::TERM_W'(cpmi_pkg::NUM_TERMS - 1)) begin
            ctl.op.kind = cpmi_pkg::OP_FACTOR;
            ctl.op.term = slot + 1'b1;
            ctl.op.dim  = cpmi_pkg::dim_of(slot + 1'b1);
          end
        end else begin
          ctl.op.kind = cpmi_pkg::OP_COEF;
          ctl.op.term = slot;
          ctl.op.dim  = sub - 2'd1;
        end
      end
      cpmi_pkg::ST_FINAL: ctl.finalize = 1'b1;
      cpmi_pkg::ST_SQUARE: begin
        ctl.op.kind = cpmi_pkg::OP_SQUARE;
        ctl.op.dim  = count[1:0];
      end
      cpmi_pkg::ST_DONE: ctl.res_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpmi_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/cpmi_dpath.sv =====
// Shared multiply-accumulate datapath: factors, accumulators, position, distance.
// Depends on cpmi_pkg and cpmi_coef_mem.
`default_nettype none

module cpmi_dpath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire cpmi_pkg::ctl_t                        ctl,
  input  wire logic                                  step_start,
  input  wire logic                                  pos_clear,
  input  wire logic                                  load_we,
  input  wire logic [cpmi_pkg::ADDR_W-1:0]           load_addr,
  input  wire logic signed [cpmi_pkg::WORD_W-1:0]    load_data,
  output logic signed [cpmi_pkg::WORD_W-1:0]         pos [cpmi_pkg::NDIM],
  output logic [cpmi_pkg::DIST_W-1:0]                dist_sq,
  output logic                                       sat_seen
);

  localparam int W = cpmi_pkg::WORD_W;

  cpmi_pkg::op_t                       op_s1, op_s2;
  logic signed [W-1:0]                 coef;
  logic signed [W-1:0]                 fac [cpmi_pkg::NUM_TERMS];
  logic [cpmi_pkg::TERM_W-1:0]         fac_idx;
  logic signed [W-1:0]                 fac_rd, mul_a, mul_b;
  logic signed [2*W-1:0]               prod;
  logic [2*W-1:0]                      psum;
  logic signed [cpmi_pkg::RND_W-1:0]   rnd;
  logic                                rnd_ovf;
  logic signed [W-1:0]                 rnd_sat;
  logic signed [cpmi_pkg::ACC_W-1:0]   acc [cpmi_pkg::NDIM];
  logic [cpmi_pkg::ADDR_W-1:0]         raddr;

  assign raddr = cpmi_pkg::ADDR_W'({ctl.op.term, 1'b0}) + cpmi_pkg::ADDR_W'(ctl.op.term)
               + cpmi_pkg::ADDR_W'(ctl.op.dim);

  cpmi_coef_mem u_mem (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (load_data),
    .raddr (raddr),
    .rdata (coef)
  );

  always_comb begin
    fac_idx = (op_s1.kind == cpmi_pkg::OP_FACTOR) ? cpmi_pkg::parent_of(op_s1.term) : op_s1.term;
    fac_rd  = (fac_idx == '0) ? cpmi_pkg::ONE : fac[fac_idx];
    unique case (op_s1.kind)
      cpmi_pkg::OP_FACTOR: begin
        mul_a = fac_rd;
        mul_b = pos[op_s1.dim];
      end
      cpmi_pkg::OP_COEF: begin
        mul_a = fac_rd;
        mul_b = coef;
      end
      cpmi_pkg::OP_SQUARE: begin
        mul_a = pos[op_s1.dim];
        mul_b = pos[op_s1.dim];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    psum    = prod + (64'd1 << (cpmi_pkg::FRAC - 1));
    rnd     = psum[2*W-1:cpmi_pkg::FRAC];
    rnd_ovf = (rnd[cpmi_pkg::RND_W-1:W-1] != '0) && (rnd[cpmi_pkg::RND_W-1:W-1] != '1);
    if (!rnd_ovf)                     rnd_sat = rnd[W-1:0];
    else if (rnd[cpmi_pkg::RND_W-1])  rnd_sat = {1'b1, {(W-1){1'b0}}};
    else                              rnd_sat = {1'b0, {(W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_s1.kind <= cpmi_pkg::OP_NONE;
      op_s2.kind <= cpmi_pkg::OP_NONE;
    end else begin
      op_s1.kind <= ctl.op.kind;
      op_s2.kind <= op_s1.kind;
    end
    op_s1.term <= ctl.op.term;
    op_s1.dim  <= ctl.op.dim;
    op_s2.term <= op_s1.term;
    op_s2.dim  <= op_s1.dim;
    prod       <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (step_start) begin
      for (int d = 0; d < cpmi_pkg::NDIM; d++) acc[d] <= '0;
      dist_sq <= '0;
    end else begin
      unique case (op_s2.kind)
        cpmi_pkg::OP_FACTOR: fac[op_s2.term] <= rnd_sat;
        cpmi_pkg::OP_COEF:
          acc[op_s2.dim] <= acc[op_s2.dim] + cpmi_pkg::ACC_W'(rnd);
        cpmi_pkg::OP_SQUARE:
          dist_sq <= dist_sq + cpmi_pkg::DIST_W'(prod[2*W-1:cpmi_pkg::FRAC]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || pos_clear) begin
      for (int d = 0; d < cpmi_pkg::NDIM; d++) pos[d] <= '0;
      sat_seen <= 1'b0;
    end else if (ctl.finalize) begin
      for (int d = 0; d < cpmi_pkg::NDIM; d++) begin
        if (acc[d] > cpmi_pkg::ACC_W'(32'sh7fffffff)) begin
          pos[d]   <= {1'b0, {(W-1){1'b1}}};
          sat_seen <= 1'b1;
        end else if (acc[d] < -cpmi_pkg::ACC_W'(33'sh080000000)) begin
          pos[d]   <= {1'b1, {(W-1){1'b0}}};
          sat_seen <= 1'b1;
        end else begin
          pos[d] <= acc[d][W-1:0];
        end
      end
    end else if (op_s2.kind == cpmi_pkg::OP_FACTOR && rnd_ovf) begin
      sat_seen <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench of cubic_poly_map_iterator: random and directed requests,
// predicted map steps compared field by field. Depends on cpmi_pkg and the design.
`timescale 1ns / 1ps
`default_nettype none

module tb;

  typedef struct {
    logic [1:0] f;
    logic [5:0] idx;
    logic [4:0] code;
  } request_t;

  typedef struct {
    int x;
    int y;
    int z;
    bit esc;
    bit ovf;
  } map_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = '0;
  logic [5:0] coeff_index = '0;
  logic [4:0] coeff_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic escaped, overflowed;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic paddr = 1'b0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  request_t pending_reqs[$];
  map_point_t points_due[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int err_count = 0;

  int coef_mem[cpmi_pkg::STORE_DEPTH];
  int pos_now[cpmi_pkg::NDIM];
  bit sat_seen;
  logic [cpmi_pkg::RAD_W-1:0] radius_sq = cpmi_pkg::RADIUS_RESET;
  longint acc_sum[cpmi_pkg::NDIM];
  int slot_ptr;

  cubic_poly_map_iterator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .coeff_index(coeff_index), .coeff_code(coeff_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .escaped(escaped), .overflowed(overflowed),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic int sat_word(longint v);
    if (v > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return 32'h80000000;
    end
    return int'(v);
  endfunction

  function automatic longint round_mul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b) + (64'sd1 <<< (cpmi_pkg::FRAC - 1));
    return p >>> cpmi_pkg::FRAC;
  endfunction

  function automatic void add_products(int f);
    for (int d = 0; d < cpmi_pkg::NDIM; d++)
      if (slot_ptr + d < cpmi_pkg::STORE_DEPTH)
        acc_sum[d] += round_mul(f, coef_mem[slot_ptr + d]);
    slot_ptr += cpmi_pkg::NDIM;
  endfunction

  function automatic void walk_terms(int f, int first, int order);
    int g;
    add_products(f);
    for (int i = first; i < cpmi_pkg::NDIM; i++) begin
      g = sat_word(round_mul(f, pos_now[i]));
      if (order > 1) walk_terms(g, i, order - 1);
      else add_products(g);
    end
  endfunction

  function automatic int coef_of(int code);
    longint n;
    n = longint'(code % 25 - 12) * (64'sd1 <<< cpmi_pkg::FRAC);
    return (n >= 0) ? int'((n + 5) / 10) : int'(-((-n + 5) / 10));
  endfunction

  function automatic void apply_request(request_t r);
    map_point_t p;
    int nxt[cpmi_pkg::NDIM];
    longint unsigned dist_acc;
    case (cpmi_pkg::func_t'(r.f))
      cpmi_pkg::FUNC_LOAD:
        if (r.idx < cpmi_pkg::STORE_DEPTH) coef_mem[r.idx] = coef_of(r.code);
      cpmi_pkg::FUNC_CLEAR: begin
        pos_now = '{0, 0, 0};
        sat_seen = 1'b0;
      end
      cpmi_pkg::FUNC_STEP: begin
        acc_sum = '{0, 0, 0};
        slot_ptr = 0;
        walk_terms(cpmi_pkg::ONE, 0, 3);
        dist_acc = 0;
        for (int d = 0; d < cpmi_pkg::NDIM; d++) begin
          nxt[d] = sat_word(acc_sum[d]);
          dist_acc += longint'(longint'(nxt[d]) * longint'(nxt[d])) >> cpmi_pkg::FRAC;
        end
        pos_now = nxt;
        p.x = nxt[0];
        p.y = nxt[1];
        p.z = nxt[2];
        p.esc = dist_acc > 64'(radius_sq);
        p.ovf = sat_seen;
        points_due.push_back(p);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    err_count++;
  endtask

  // driver
  always @(posedge clk) begin
    request_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_request('{func, coeff_index, coeff_code});
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          r = pending_reqs.pop_front();
          func <= r.f;
          coeff_index <= r.idx;
          coeff_code <= r.code;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    map_point_t e;
    if (!rst && out_valid && out_ready) begin
      if (points_due.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = points_due.pop_front();
        if (pos_x !== e.x) report_mismatch("pos_x", pos_x, e.x);
        if (pos_y !== e.y) report_mismatch("pos_y", pos_y, e.y);
        if (pos_z !== e.z) report_mismatch("pos_z", pos_z, e.z);
        if (escaped !== e.esc) report_mismatch("escaped", escaped, e.esc);
        if (overflowed !== e.ovf) report_mismatch("overflowed", overflowed, e.ovf);
      end
    end
  end

  function automatic void push_req(int f, int idx, int code);
    pending_reqs.push_back('{f[1:0], idx[5:0], code[4:0]});
  endfunction

  task automatic drain_all();
    while (pending_reqs.size() > 0 || in_valid || points_due.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_radius(logic [cpmi_pkg::RAD_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 1'b0;
    pwdata <= 64'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    radius_sq = v;
  endtask

  function automatic void random_phase(int n);
    int cnt;
    int k;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(9) == 0) begin
        push_req($urandom_range(3), $urandom_range(63), $urandom_range(31));
        cnt++;
      end else begin
        if ($urandom_range(3) == 0) begin
          push_req(cpmi_pkg::FUNC_CLEAR, $urandom_range(63), $urandom_range(31));
          cnt++;
        end
        k = $urandom_range(6);
        repeat (k) begin
          push_req(cpmi_pkg::FUNC_LOAD, $urandom_range(cpmi_pkg::STORE_DEPTH - 1),
                   $urandom_range(1) ? $urandom_range(9, 15) : $urandom_range(31));
          cnt++;
        end
        k = $urandom_range(1, 6);
        repeat (k) begin
          push_req(cpmi_pkg::FUNC_STEP, $urandom_range(63), $urandom_range(31));
          cnt++;
        end
      end
    end
  endfunction

  initial begin
    logic [cpmi_pkg::RAD_W-1:0] rnd_rad;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < cpmi_pkg::STORE_DEPTH; i++)
      push_req(cpmi_pkg::FUNC_LOAD, i, $urandom_range(10, 14));
    push_req(cpmi_pkg::FUNC_STEP, 0, 0);
    push_req(cpmi_pkg::FUNC_LOAD, 0, 24);
    push_req(cpmi_pkg::FUNC_LOAD, 59, 0);
    push_req(cpmi_pkg::FUNC_LOAD, 1, 31);
    push_req(cpmi_pkg::FUNC_LOAD, 63, 31);
    push_req(cpmi_pkg::FUNC_LOAD, 60, 5);
    push_req(cpmi_pkg::FUNC_NONE, 63, 31);
    push_req(cpmi_pkg::FUNC_STEP, 63, 31);
    push_req(cpmi_pkg::FUNC_STEP, 0, 0);
    push_req(cpmi_pkg::FUNC_STEP, 21, 10);
    push_req(cpmi_pkg::FUNC_CLEAR, 0, 0);
    push_req(cpmi_pkg::FUNC_STEP, 0, 0);
    push_req(cpmi_pkg::FUNC_LOAD, 3, 24);
    push_req(cpmi_pkg::FUNC_LOAD, 37, 0);
    for (int i = 0; i < 8; i++) push_req(cpmi_pkg::FUNC_STEP, i, i);
    push_req(cpmi_pkg::FUNC_CLEAR, 42, 21);
    push_req(cpmi_pkg::FUNC_STEP, 0, 0);
    drain_all();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: write_radius('0);
        2: write_radius('1);
        3: begin
          rnd_rad = {8'($urandom), 32'($urandom)} >> $urandom_range(24);
          write_radius(rnd_rad);
        end
        default: ;
      endcase
      idle_pct = (ph == 1) ? 67 : (ph == 3) ? 16 : 0;
      stall_pct = (ph == 2) ? 67 : (ph == 3) ? 16 : 0;
      random_phase(100);
      drain_all();
      random_phase(100);
      drain_all();
    end
    write_radius(cpmi_pkg::RADIUS_RESET);

    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
